### rtl/core/wpsp_pkg.sv
// Shared types, phase codes and constants for the RIFF/WAVE PCM stream parser.
// No dependencies.
package wpsp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic signed [15:0] sample_value;
    logic [15:0] channel;
    logic        last_sample;
    logic [2:0]  error_code;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [4:0]  bits_per_sample;
    logic [31:0] sample_count;
  } out_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NOT_RIFF   = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE   = 3'd1;
  localparam logic [2:0] ERR_NO_FMT     = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM    = 3'd3;
  localparam logic [2:0] ERR_COMPRESSED = 3'd4;
  localparam logic [2:0] ERR_BAD_WIDTH  = 3'd5;
  localparam logic [2:0] ERR_MISMATCH   = 3'd6;

  localparam logic [4:0] PH_RIFF      = 5'd0;
  localparam logic [4:0] PH_RIFFSZ    = 5'd1;
  localparam logic [4:0] PH_WAVE      = 5'd2;
  localparam logic [4:0] PH_FMT       = 5'd3;
  localparam logic [4:0] PH_FMTSZ     = 5'd4;
  localparam logic [4:0] PH_AFMT      = 5'd5;
  localparam logic [4:0] PH_CH        = 5'd6;
  localparam logic [4:0] PH_RATE      = 5'd7;
  localparam logic [4:0] PH_BRATE     = 5'd8;
  localparam logic [4:0] PH_BALIGN    = 5'd9;
  localparam logic [4:0] PH_BITS      = 5'd10;
  localparam logic [4:0] PH_CKID      = 5'd11;
  localparam logic [4:0] PH_CKSZ      = 5'd12;
  localparam logic [4:0] PH_DATASZ    = 5'd13;
  localparam logic [4:0] PH_SKIP_EVEN = 5'd14;
  localparam logic [4:0] PH_SKIP_ODD  = 5'd15;
  localparam logic [4:0] PH_PAD       = 5'd16;
  localparam logic [4:0] PH_SAMPLE    = 5'd17;
  localparam logic [4:0] PH_DONE      = 5'd18;
  localparam logic [4:0] PH_CHECK     = 5'd19;
  localparam logic [4:0] PH_DIV       = 5'd20;
  localparam logic [4:0] PH_HEADER    = 5'd21;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_SIZE = 32'd16;
  localparam logic [31:0] FMT_PCM  = 32'd1;

  localparam int QUEUE_DEPTH = 2;

  function automatic out_t error_beat(input logic [2:0] code);
    out_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

### rtl/core/wav_pcm_stream_parser_core.sv
// RIFF/WAVE PCM stream parser, top level.
// Byte beats come in on byte_valid/byte_ready with byte_beat; results leave on
// result_valid/result_ready with result_beat (header, sample or error).
// A beat with start_of_file set restarts the parse at the RIFF tag.
// Throughput: one byte per cycle through tags, fields, skipped chunks and
// sample data, while the result register is free or being taken. After the
// bits-per-sample field a check state compares the byte rate and block align
// (the 32x16 multiply is registered with the field, then compared). After the
// data size field a radix-2 divider finds the frame count, then the header
// beat is sent; no bytes are taken meanwhile. An accepted byte reaches its
// result through the two-entry input queue and the output register.
// Reset (synchronous, rst high) empties the queue, drops any pending result
// and arms the parser for a RIFF tag. When the receiver stalls the result
// register holds its beat, the parser stops, and the input queue fills and
// then deasserts byte_ready. After an error or the last sample, bytes are
// taken and dropped until the next start_of_file.
// Depends on wpsp_pkg, wpsp_front and wpsp_back.
module wav_pcm_stream_parser_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  wpsp_pkg::in_t  byte_beat,
  output logic           result_valid,
  input  logic           result_ready,
  output wpsp_pkg::out_t result_beat
);

  logic          q_valid;
  logic          q_pop;
  wpsp_pkg::in_t q_data;

  wpsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_beat  (byte_beat),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data)
  );

  wpsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_data       (q_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_beat  (result_beat)
  );

endmodule

### rtl/core/wpsp_front.sv
// Front end: accepts byte beats and holds them in a short queue for the parser.
// Depends on wpsp_pkg.
module wpsp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  wpsp_pkg::in_t byte_beat,
  output logic          q_valid,
  input  logic          q_pop,
  output wpsp_pkg::in_t q_data
);

  wpsp_pkg::in_t slots [wpsp_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign byte_ready = (count != 2'(wpsp_pkg::QUEUE_DEPTH));
  assign push       = byte_valid && byte_ready;
  assign q_valid    = (count != 2'd0);
  assign q_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= byte_beat;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### rtl/core/wpsp_back.sv
// Back end: header parse, field checks, frame-count divider and sample decode.
// Depends on wpsp_pkg.
module wpsp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  wpsp_pkg::in_t  q_data,
  output logic           result_valid,
  input  logic           result_ready,
  output wpsp_pkg::out_t result_beat
);

  logic [4:0]  phase, phase_next;
  logic [1:0]  fidx, fidx_next;
  logic [31:0] fshift, fshift_next;
  logic [31:0] skip_rem, skip_rem_next;
  logic [15:0] ch_reg, ch_reg_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [31:0] brate_reg, brate_reg_next;
  logic [15:0] balign_reg, balign_reg_next;
  logic [4:0]  width_reg, width_reg_next;
  logic [31:0] frames_left, frames_left_next;
  logic [15:0] ch_cnt, ch_cnt_next;
  logic [7:0]  low_hold, low_hold_next;
  logic [31:0] prod, prod_next;
  logic [31:0] div_q, div_q_next;
  logic [16:0] div_rem, div_rem_next;
  logic [4:0]  div_cnt, div_cnt_next;
  logic        out_valid, out_valid_next;
  wpsp_pkg::out_t out_data, out_data_next;

  logic        can_go, busy, step, emit, field_done, flen2, is16, wrap, last;
  logic [4:0]  ph_eff;
  logic [1:0]  idx_eff;
  logic [7:0]  b;
  logic [31:0] v, br;
  logic [16:0] ba, divisor, cnt1;
  logic [17:0] trial;
  logic [47:0] mul;
  logic [15:0] sval;
  wpsp_pkg::out_t emit_data;

  assign can_go = !out_valid || result_ready;
  assign busy   = (phase == wpsp_pkg::PH_CHECK) || (phase == wpsp_pkg::PH_DIV) ||
                  (phase == wpsp_pkg::PH_HEADER);
  assign step   = q_valid && can_go && !busy;
  assign q_pop  = step;
  assign result_valid = out_valid;
  assign result_beat  = out_data;

  assign b       = q_data.byte_value;
  assign ph_eff  = q_data.start_of_file ? wpsp_pkg::PH_RIFF : phase;
  assign idx_eff = q_data.start_of_file ? 2'd0 : fidx;
  assign v       = (idx_eff == 2'd0) ? {24'd0, b}
                                     : (fshift | ({24'd0, b} << {idx_eff, 3'b000}));
  assign flen2   = (ph_eff == wpsp_pkg::PH_AFMT) || (ph_eff == wpsp_pkg::PH_CH) ||
                   (ph_eff == wpsp_pkg::PH_BALIGN) || (ph_eff == wpsp_pkg::PH_BITS);
  assign field_done = flen2 ? (idx_eff != 2'd0) : (idx_eff == 2'd3);
  assign is16    = (width_reg == 5'd16);
  assign mul     = rate_reg * {16'd0, ch_reg};
  assign br      = is16 ? {3'd0, prod[27:0], 1'b0} : {3'd0, prod[28:0]};
  assign ba      = is16 ? {ch_reg, 1'b0} : {1'b0, ch_reg};
  assign divisor = ba;
  assign trial   = {div_rem, div_q[31]};
  assign cnt1    = {1'b0, ch_cnt} + 17'd1;
  assign wrap    = cnt1 >= {1'b0, ch_reg};
  assign last    = (frames_left <= 32'd1) && wrap;
  assign sval    = is16 ? {b, low_hold} : ({8'd0, b} + 16'hFF80);

  always_comb begin
    phase_next       = phase;
    fidx_next        = fidx;
    fshift_next      = fshift;
    skip_rem_next    = skip_rem;
    ch_reg_next      = ch_reg;
    rate_reg_next    = rate_reg;
    brate_reg_next   = brate_reg;
    balign_reg_next  = balign_reg;
    width_reg_next   = width_reg;
    frames_left_next = frames_left;
    ch_cnt_next      = ch_cnt;
    low_hold_next    = low_hold;
    prod_next        = prod;
    div_q_next       = div_q;
    div_rem_next     = div_rem;
    div_cnt_next     = div_cnt;
    emit             = 1'b0;
    emit_data        = '0;

    if (step) begin
      phase_next = ph_eff;
      fidx_next  = idx_eff;
      if (ph_eff <= wpsp_pkg::PH_DATASZ) begin
        fshift_next = v;
        if (!field_done) begin
          fidx_next = idx_eff + 2'd1;
        end else begin
          fidx_next = 2'd0;
          case (ph_eff)
            wpsp_pkg::PH_RIFF: begin
              if (v != wpsp_pkg::TAG_RIFF) begin
                emit = 1'b1;
                emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_NOT_RIFF);
                phase_next = wpsp_pkg::PH_DONE;
              end else phase_next = wpsp_pkg::PH_RIFFSZ;
            end
            wpsp_pkg::PH_RIFFSZ: phase_next = wpsp_pkg::PH_WAVE;
            wpsp_pkg::PH_WAVE: begin
              if (v != wpsp_pkg::TAG_WAVE) begin
                emit = 1'b1;
                emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_NOT_WAVE);
                phase_next = wpsp_pkg::PH_DONE;
              end else phase_next = wpsp_pkg::PH_FMT;
            end
            wpsp_pkg::PH_FMT: begin
              if (v != wpsp_pkg::TAG_FMT) begin
                emit = 1'b1;
                emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_NO_FMT);
                phase_next = wpsp_pkg::PH_DONE;
              end else phase_next = wpsp_pkg::PH_FMTSZ;
            end
            wpsp_pkg::PH_FMTSZ: begin
              if (v != wpsp_pkg::FMT_SIZE) begin
                emit = 1'b1;
                emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_NOT_PCM);
                phase_next = wpsp_pkg::PH_DONE;
              end else phase_next = wpsp_pkg::PH_AFMT;
            end
            wpsp_pkg::PH_AFMT: begin
              if (v != wpsp_pkg::FMT_PCM) begin
                emit = 1'b1;
                emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_COMPRESSED);
                phase_next = wpsp_pkg::PH_DONE;
              end else phase_next = wpsp_pkg::PH_CH;
            end
            wpsp_pkg::PH_CH: begin
              ch_reg_next = v[15:0];
              phase_next  = wpsp_pkg::PH_RATE;
            end
            wpsp_pkg::PH_RATE: begin
              rate_reg_next = v;
              phase_next    = wpsp_pkg::PH_BRATE;
            end
            wpsp_pkg::PH_BRATE: begin
              brate_reg_next = v;
              phase_next     = wpsp_pkg::PH_BALIGN;
            end
            wpsp_pkg::PH_BALIGN: begin
              balign_reg_next = v[15:0];
              phase_next      = wpsp_pkg::PH_BITS;
            end
            wpsp_pkg::PH_BITS: begin
              if (v[15:0] != 16'd8 && v[15:0] != 16'd16) begin
                emit = 1'b1;
                emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_BAD_WIDTH);
                phase_next = wpsp_pkg::PH_DONE;
              end else begin
                width_reg_next = v[4:0];
                if (ch_reg == 16'd0) begin
                  emit = 1'b1;
                  emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_MISMATCH);
                  phase_next = wpsp_pkg::PH_DONE;
                end else begin
                  prod_next  = mul[31:0];
                  phase_next = wpsp_pkg::PH_CHECK;
                end
              end
            end
            wpsp_pkg::PH_CKID:
              phase_next = (v == wpsp_pkg::TAG_DATA) ? wpsp_pkg::PH_DATASZ
                                                     : wpsp_pkg::PH_CKSZ;
            wpsp_pkg::PH_CKSZ: begin
              if (v == 32'd0) phase_next = wpsp_pkg::PH_CKID;
              else begin
                skip_rem_next = v;
                phase_next = v[0] ? wpsp_pkg::PH_SKIP_ODD : wpsp_pkg::PH_SKIP_EVEN;
              end
            end
            wpsp_pkg::PH_DATASZ: begin
              div_q_next   = v;
              div_rem_next = 17'd0;
              div_cnt_next = 5'd0;
              ch_cnt_next  = 16'd0;
              phase_next   = wpsp_pkg::PH_DIV;
            end
            default: phase_next = wpsp_pkg::PH_DONE;
          endcase
        end
      end else begin
        case (ph_eff)
          wpsp_pkg::PH_SKIP_EVEN, wpsp_pkg::PH_SKIP_ODD: begin
            skip_rem_next = skip_rem - 32'd1;
            if (skip_rem == 32'd1)
              phase_next = (ph_eff == wpsp_pkg::PH_SKIP_ODD) ? wpsp_pkg::PH_PAD
                                                             : wpsp_pkg::PH_CKID;
          end
          wpsp_pkg::PH_PAD: phase_next = wpsp_pkg::PH_CKID;
          wpsp_pkg::PH_SAMPLE: begin
            if (is16 && fidx == 2'd0) begin
              low_hold_next = b;
              fidx_next     = 2'd1;
            end else begin
              fidx_next = 2'd0;
              emit = 1'b1;
              emit_data.kind         = wpsp_pkg::KIND_SAMPLE;
              emit_data.sample_value = sval;
              emit_data.channel      = ch_cnt;
              emit_data.last_sample  = last;
              if (wrap) begin
                ch_cnt_next      = 16'd0;
                frames_left_next = frames_left - 32'd1;
              end else begin
                ch_cnt_next = cnt1[15:0];
              end
              if (last) phase_next = wpsp_pkg::PH_DONE;
            end
          end
          default: phase_next = ph_eff;
        endcase
      end
    end else begin
      case (phase)
        wpsp_pkg::PH_CHECK: begin
          if (can_go) begin
            if (br != brate_reg || ba != {1'b0, balign_reg}) begin
              emit = 1'b1;
              emit_data = wpsp_pkg::error_beat(wpsp_pkg::ERR_MISMATCH);
              phase_next = wpsp_pkg::PH_DONE;
            end else phase_next = wpsp_pkg::PH_CKID;
          end
        end
        wpsp_pkg::PH_DIV: begin
          if (trial >= {1'b0, divisor}) begin
            div_rem_next = 17'(trial - {1'b0, divisor});
            div_q_next   = {div_q[30:0], 1'b1};
          end else begin
            div_rem_next = trial[16:0];
            div_q_next   = {div_q[30:0], 1'b0};
          end
          div_cnt_next = div_cnt + 5'd1;
          if (div_cnt == 5'd31) phase_next = wpsp_pkg::PH_HEADER;
        end
        wpsp_pkg::PH_HEADER: begin
          if (can_go) begin
            emit = 1'b1;
            emit_data.kind            = wpsp_pkg::KIND_HEADER;
            emit_data.num_channels    = ch_reg;
            emit_data.sample_rate     = rate_reg;
            emit_data.bits_per_sample = width_reg;
            emit_data.sample_count    = div_q;
            frames_left_next = div_q;
            phase_next = (div_q != 32'd0) ? wpsp_pkg::PH_SAMPLE : wpsp_pkg::PH_DONE;
          end
        end
        default: phase_next = phase;
      endcase
    end

    out_valid_next = out_valid && !result_ready;
    out_data_next  = out_data;
    if (emit) begin
      out_valid_next = 1'b1;
      out_data_next  = emit_data;
    end
  end

  always_ff @(posedge clk) begin
    fshift      <= fshift_next;
    skip_rem    <= skip_rem_next;
    ch_reg      <= ch_reg_next;
    rate_reg    <= rate_reg_next;
    brate_reg   <= brate_reg_next;
    balign_reg  <= balign_reg_next;
    width_reg   <= width_reg_next;
    frames_left <= frames_left_next;
    ch_cnt      <= ch_cnt_next;
    low_hold    <= low_hold_next;
    prod        <= prod_next;
    div_q       <= div_q_next;
    div_rem     <= div_rem_next;
    div_cnt     <= div_cnt_next;
    out_data    <= out_data_next;
    if (rst) begin
      phase       <= wpsp_pkg::PH_RIFF;
      fidx        <= 2'd0;
      out_valid   <= 1'b0;
      ch_reg      <= 16'd0;
      width_reg   <= 5'd0;
      frames_left <= 32'd0;
      ch_cnt      <= 16'd0;
    end else begin
      phase     <= phase_next;
      fidx      <= fidx_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_pop) else $error("queue popped while parser busy");

  a_sample_from_phase: assert property (@(posedge clk) disable iff (rst)
    emit && emit_data.kind == wpsp_pkg::KIND_SAMPLE |-> phase == wpsp_pkg::PH_SAMPLE)
    else $error("sample beat outside data chunk");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    phase == wpsp_pkg::PH_SAMPLE |-> ch_cnt < ch_reg)
    else $error("channel counter out of range");

  a_reset_phase: assert property (@(posedge clk)
    rst |=> phase == wpsp_pkg::PH_RIFF && !out_valid)
    else $error("bad state after reset");

endmodule

### tb/wpsp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for wav_pcm_stream_parser_core: follows both channels, predicts the
// results of each accepted byte beat and compares them field by field. Uses wpsp_pkg.
module wpsp_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  input  logic           byte_ready,
  input  wpsp_pkg::in_t  byte_beat,
  input  logic           result_valid,
  input  logic           result_ready,
  input  wpsp_pkg::out_t result_beat,
  output int             fail_count,
  output int             pending,
  output int             headers_seen,
  output int             samples_seen,
  output int             errors_seen
);

  wpsp_pkg::out_t expected_q[$];
  logic [4:0]  phase;
  logic [1:0]  byte_idx;
  logic [31:0] shift_acc;
  logic [31:0] skip_left;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [31:0] byte_rate;
  logic [15:0] blk_align;
  logic [4:0]  width;
  logic [31:0] frames_left;
  logic [15:0] chan_ctr;
  logic [7:0]  low_hold;

  assign pending = expected_q.size();

  task automatic parser_reset();
    phase = wpsp_pkg::PH_RIFF; byte_idx = 0; shift_acc = 0; skip_left = 0; chans = 0;
    rate = 0; byte_rate = 0; blk_align = 0; width = 0; frames_left = 0;
    chan_ctr = 0; low_hold = 0;
  endtask

  function automatic wpsp_pkg::out_t err(input logic [2:0] code);
    wpsp_pkg::out_t r;
    r = '0;
    r.kind = wpsp_pkg::KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  task automatic field_done(input logic [31:0] v);
    logic [31:0] br, ba, dv, fr;
    wpsp_pkg::out_t r;
    case (phase)
      wpsp_pkg::PH_RIFF: if (v != wpsp_pkg::TAG_RIFF) begin
        expected_q.push_back(err(wpsp_pkg::ERR_NOT_RIFF)); phase = wpsp_pkg::PH_DONE;
      end else phase = wpsp_pkg::PH_RIFFSZ;
      wpsp_pkg::PH_RIFFSZ: phase = wpsp_pkg::PH_WAVE;
      wpsp_pkg::PH_WAVE: if (v != wpsp_pkg::TAG_WAVE) begin
        expected_q.push_back(err(wpsp_pkg::ERR_NOT_WAVE)); phase = wpsp_pkg::PH_DONE;
      end else phase = wpsp_pkg::PH_FMT;
      wpsp_pkg::PH_FMT: if (v != wpsp_pkg::TAG_FMT) begin
        expected_q.push_back(err(wpsp_pkg::ERR_NO_FMT)); phase = wpsp_pkg::PH_DONE;
      end else phase = wpsp_pkg::PH_FMTSZ;
      wpsp_pkg::PH_FMTSZ: if (v != wpsp_pkg::FMT_SIZE) begin
        expected_q.push_back(err(wpsp_pkg::ERR_NOT_PCM)); phase = wpsp_pkg::PH_DONE;
      end else phase = wpsp_pkg::PH_AFMT;
      wpsp_pkg::PH_AFMT: if (v != wpsp_pkg::FMT_PCM) begin
        expected_q.push_back(err(wpsp_pkg::ERR_COMPRESSED)); phase = wpsp_pkg::PH_DONE;
      end else phase = wpsp_pkg::PH_CH;
      wpsp_pkg::PH_CH: begin chans = v[15:0]; phase = wpsp_pkg::PH_RATE; end
      wpsp_pkg::PH_RATE: begin rate = v; phase = wpsp_pkg::PH_BRATE; end
      wpsp_pkg::PH_BRATE: begin byte_rate = v; phase = wpsp_pkg::PH_BALIGN; end
      wpsp_pkg::PH_BALIGN: begin blk_align = v[15:0]; phase = wpsp_pkg::PH_BITS; end
      wpsp_pkg::PH_BITS: begin
        v = {16'd0, v[15:0]};
        if (v != 32'd8 && v != 32'd16) begin
          expected_q.push_back(err(wpsp_pkg::ERR_BAD_WIDTH)); phase = wpsp_pkg::PH_DONE;
        end else begin
          width = v[4:0];
          br = (rate * {16'd0, chans} * {27'd0, width}) / 32'd8;
          ba = ({16'd0, chans} * {27'd0, width}) / 32'd8;
          if (chans == 0 || br != byte_rate || ba != {16'd0, blk_align}) begin
            expected_q.push_back(err(wpsp_pkg::ERR_MISMATCH)); phase = wpsp_pkg::PH_DONE;
          end else phase = wpsp_pkg::PH_CKID;
        end
      end
      wpsp_pkg::PH_CKID:
        phase = (v == wpsp_pkg::TAG_DATA) ? wpsp_pkg::PH_DATASZ : wpsp_pkg::PH_CKSZ;
      wpsp_pkg::PH_CKSZ: if (v == 0) phase = wpsp_pkg::PH_CKID;
        else begin
          skip_left = v;
          phase = v[0] ? wpsp_pkg::PH_SKIP_ODD : wpsp_pkg::PH_SKIP_EVEN;
        end
      wpsp_pkg::PH_DATASZ: begin
        dv = {27'd0, width >> 3} * {16'd0, chans};
        fr = (dv != 0) ? v / dv : 32'd0;
        frames_left = fr; chan_ctr = 0; byte_idx = 0;
        r = '0;
        r.kind = wpsp_pkg::KIND_HEADER;
        r.num_channels = chans;
        r.sample_rate = rate;
        r.bits_per_sample = width;
        r.sample_count = fr;
        expected_q.push_back(r);
        phase = (fr != 0) ? wpsp_pkg::PH_SAMPLE : wpsp_pkg::PH_DONE;
      end
      default: phase = wpsp_pkg::PH_DONE;
    endcase
  endtask

  task automatic predict_byte(input wpsp_pkg::in_t bt);
    logic [7:0]  b;
    logic [15:0] val;
    logic        lst, wrap;
    int          flen;
    wpsp_pkg::out_t r;
    b = bt.byte_value;
    if (bt.start_of_file) begin
      phase = wpsp_pkg::PH_RIFF; byte_idx = 0;
    end
    if (phase <= wpsp_pkg::PH_DATASZ) begin
      if (byte_idx == 0) shift_acc = {24'd0, b};
      else shift_acc = shift_acc | ({24'd0, b} << (8 * byte_idx));
      flen = (phase == wpsp_pkg::PH_AFMT || phase == wpsp_pkg::PH_CH ||
              phase == wpsp_pkg::PH_BALIGN || phase == wpsp_pkg::PH_BITS) ? 2 : 4;
      if (byte_idx + 1 < flen) byte_idx = byte_idx + 1;
      else begin
        byte_idx = 0;
        field_done(shift_acc);
      end
    end else begin
      case (phase)
        wpsp_pkg::PH_SKIP_EVEN, wpsp_pkg::PH_SKIP_ODD: begin
          skip_left = skip_left - 1;
          if (skip_left == 0)
            phase = (phase == wpsp_pkg::PH_SKIP_ODD) ? wpsp_pkg::PH_PAD
                                                     : wpsp_pkg::PH_CKID;
        end
        wpsp_pkg::PH_PAD: phase = wpsp_pkg::PH_CKID;
        wpsp_pkg::PH_SAMPLE: begin
          if (width == 5'd16 && byte_idx == 0) begin
            low_hold = b; byte_idx = 1;
          end else begin
            if (width == 5'd16) begin
              byte_idx = 0; val = {b, low_hold};
            end else val = {8'd0, b} + 16'hFF80;
            wrap = ({16'd0, chan_ctr} + 32'd1) >= {16'd0, chans};
            lst = (frames_left <= 1) && wrap;
            r = '0;
            r.kind = wpsp_pkg::KIND_SAMPLE;
            r.sample_value = val;
            r.channel = chan_ctr;
            r.last_sample = lst;
            expected_q.push_back(r);
            if (wrap) begin
              chan_ctr = 0; frames_left = frames_left - 1;
            end else chan_ctr = chan_ctr + 1;
            if (lst) phase = wpsp_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  endtask

  function automatic int field_diff(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: mismatch %s expected %0h actual %0h", $time, nm, e, a);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    fail_count = 0; headers_seen = 0; samples_seen = 0; errors_seen = 0;
    parser_reset();
  end

  always @(posedge clk) begin
    wpsp_pkg::out_t e;
    int   d;
    if (rst) begin
      parser_reset();
      expected_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %0h", $time, result_beat);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          d = field_diff("kind", e.kind, result_beat.kind)
            + field_diff("sample_value", e.sample_value, result_beat.sample_value)
            + field_diff("channel", e.channel, result_beat.channel)
            + field_diff("last_sample", e.last_sample, result_beat.last_sample)
            + field_diff("error_code", e.error_code, result_beat.error_code)
            + field_diff("num_channels", e.num_channels, result_beat.num_channels)
            + field_diff("sample_rate", e.sample_rate, result_beat.sample_rate)
            + field_diff("bits_per_sample", e.bits_per_sample,
                         result_beat.bits_per_sample)
            + field_diff("sample_count", e.sample_count, result_beat.sample_count);
          if (d != 0) fail_count++;
          case (e.kind)
            wpsp_pkg::KIND_HEADER: headers_seen++;
            wpsp_pkg::KIND_SAMPLE: samples_seen++;
            default:               errors_seen++;
          endcase
        end
      end
      if (byte_valid && byte_ready) predict_byte(byte_beat);
    end
  end

endmodule

### tb/tb_wav_pcm_stream_parser_core.sv
`timescale 1ns / 100ps
// Top of the wav_pcm_stream_parser_core testbench: clock, reset, WAV byte stimulus,
// receiver back-pressure and verdict. Depends on wpsp_pkg, wav_pcm_stream_parser_core and wpsp_checker.
module tb_wav_pcm_stream_parser_core;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  wpsp_pkg::in_t  byte_beat = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  wpsp_pkg::out_t result_beat;

  int   fail_count, pending, headers_seen, samples_seen, errors_seen;
  int   bytes_sent = 0;
  int   idle_cycles = 0;
  bit   hold_req = 0;
  wpsp_pkg::in_t  file_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wav_pcm_stream_parser_core u_dut (
    .clk, .rst, .byte_valid, .byte_ready, .byte_beat,
    .result_valid, .result_ready, .result_beat
  );

  wpsp_checker u_chk (
    .clk, .rst, .byte_valid, .byte_ready, .byte_beat,
    .result_valid, .result_ready, .result_beat,
    .fail_count, .pending, .headers_seen, .samples_seen, .errors_seen
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int hold, g;
    hold = 0; g = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0; hold = 400;
      end
      if (hold > 0) begin
        hold--; result_ready <= 1'b0;
      end else if (g > 0) begin
        g--; result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) g = gap_len();
      end
    end
  end

  function automatic void put8(logic [7:0] b);
    wpsp_pkg::in_t t;
    t.byte_value = b;
    t.start_of_file = (file_q.size() == 0);
    file_q.push_back(t);
  endfunction

  function automatic void put16(logic [15:0] v);
    put8(v[7:0]); put8(v[15:8]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[15:0]); put16(v[31:16]);
  endfunction

  // fault: 0 clean, 1 flipped bit in the header, 2 odd width, 3 zero channels,
  // 4 rate mismatch, 5 huge data size (cut short), 6 noise
  function automatic void build_file(int fault);
    logic [15:0] ch, bits;
    logic [31:0] rate, brate, dsize, id;
    int          frames, nchunk, sz, pos, nb;
    file_q.delete();
    if (fault == 6) begin
      nb = $urandom_range(4, 30);
      for (int i = 0; i < nb; i++) put8($urandom);
      return;
    end
    ch = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
    if (fault == 3) ch = 0;
    bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
    if (fault == 2) bits = ($urandom_range(0, 1)) ? 16'($urandom) : 16'd24;
    rate = $urandom;
    brate = (rate * {16'd0, ch} * {16'd0, bits}) / 32'd8;
    if (fault == 4) brate = brate ^ (32'd1 << $urandom_range(0, 31));
    put32(wpsp_pkg::TAG_RIFF); put32($urandom); put32(wpsp_pkg::TAG_WAVE);
    put32(wpsp_pkg::TAG_FMT);
    put32(wpsp_pkg::FMT_SIZE); put16(16'(wpsp_pkg::FMT_PCM)); put16(ch); put32(rate);
    put32(brate);
    put16(16'(({16'd0, ch} * {16'd0, bits}) / 32'd8)); put16(bits);
    nchunk = $urandom_range(0, 2);
    for (int c = 0; c < nchunk; c++) begin
      do id = $urandom; while (id == wpsp_pkg::TAG_DATA);
      sz = $urandom_range(0, 5);
      put32(id); put32(sz);
      for (int i = 0; i < sz + (sz % 2); i++) put8($urandom);
    end
    frames = $urandom_range(0, 5);
    dsize = frames * ch * (bits / 8) + $urandom_range(0, 2);
    if (fault == 5) dsize = $urandom;
    put32(wpsp_pkg::TAG_DATA); put32(dsize);
    nb = (fault == 5 || ch > 3) ? $urandom_range(0, 24) : dsize + $urandom_range(0, 3);
    for (int i = 0; i < nb; i++) put8($urandom);
    if (fault == 1) begin
      pos = $urandom_range(0, 21);
      file_q[pos].byte_value[$urandom_range(0, 7)] ^= 1'b1;
    end
  endfunction

  task automatic send_file();
    int g;
    foreach (file_q[i]) begin
      @(negedge clk);
      byte_valid <= 1'b1;
      byte_beat <= file_q[i];
      do @(posedge clk); while (!byte_ready);
      bytes_sent++;
      g = gap_len();
      if (g > 0 || i == file_q.size() - 1) begin
        @(negedge clk);
        byte_valid <= 1'b0;
        repeat (g > 0 ? g - 1 : 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: every header error code, then a clean file under a long stall
    for (int k = 0; k < 5; k++) begin
      build_file(0);
      file_q[k < 2 ? 8 * k : (k == 2 ? 12 : (k == 3 ? 16 : 20))].byte_value ^= 8'h40;
      while (file_q.size() > 24) void'(file_q.pop_back());
      send_file();
    end
    for (int k = 2; k <= 4; k++) begin
      build_file(k); send_file();
    end
    build_file(0);
    hold_req = 1;
    send_file();
    while (bytes_sent < 500) begin
      case ($urandom_range(0, 19))
        0, 1:    build_file(1);
        2:       build_file(2);
        3:       build_file(3);
        4:       build_file(4);
        5, 6:    build_file(5);
        7:       build_file(6);
        default: build_file(0);
      endcase
      send_file();
    end
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d bytes; checked %0d headers, %0d samples, %0d error beats.",
             bytes_sent, headers_seen, samples_seen, errors_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
